FILE: hw/rtl/rhc_pkg.sv
// Shared codes for the RGB/HSL colour converter.
`timescale 1ns / 1ps
package rhc_pkg;
	// conversion direction, as written to the config register
	localparam logic DIR_RGB2HSL = 1'b0;
	localparam logic DIR_HSL2RGB = 1'b1;

	// segment of the hue ramp a channel sits on (units of 1/6 turn)
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;
endpackage

FILE: hw/rtl/rhc_if.sv
// Pixel stream interfaces: input components and converted result.
`timescale 1ns / 1ps
interface rhc_in_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] comp_a;
	logic [W-1:0] comp_b;
	logic [W-1:0] comp_c;
	modport source (output valid, comp_a, comp_b, comp_c, input ready);
	modport sink (input valid, comp_a, comp_b, comp_c, output ready);
endinterface

interface rhc_out_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] out_a;
	logic [W-1:0] out_b;
	logic [W-1:0] out_c;
	modport source (output valid, out_a, out_b, out_c, input ready);
	modport sink (input valid, out_a, out_b, out_c, output ready);
endinterface

FILE: hw/rtl/rhc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rhc_div #(
	parameter int DW = 20,
	parameter int QW = 17
) (
	input  logic                clk,
	input  logic                en,
	input  logic [DW+QW-1:0]    num,
	input  logic [DW-1:0]       den,
	output logic [QW-1:0]       quo
);
	// caller guarantees num / den < 2**QW, so the top DW bits start below den
	logic [DW-1:0] rem_q  [QW];
	logic [QW-1:0] low_q  [QW];
	logic [DW-1:0] den_q  [QW];
	logic [QW-1:0] quo_q  [QW];

	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_stage
			logic [DW-1:0] rem_p;
			logic [QW-1:0] low_p;
			logic [DW-1:0] den_p;
			logic [QW-1:0] quo_p;
			logic [DW:0]   trial;
			logic          take;

			if (i == 0) begin : g_first
				assign rem_p = num[DW+QW-1:QW];
				assign low_p = num[QW-1:0];
				assign den_p = den;
				assign quo_p = '0;
			end else begin : g_next
				assign rem_p = rem_q[i-1];
				assign low_p = low_q[i-1];
				assign den_p = den_q[i-1];
				assign quo_p = quo_q[i-1];
			end

			assign trial = {rem_p, low_p[QW-1]};
			assign take  = trial >= {1'b0, den_p};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i] <= take ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
					low_q[i] <= {low_p[QW-2:0], 1'b0};
					den_q[i] <= den_p;
					quo_q[i] <= {quo_p[QW-2:0], take};
				end
			end
		end
	endgenerate

	assign quo = quo_q[QW-1];
endmodule

FILE: hw/rtl/rhc_lane.sv
// One output channel of HSL to RGB: piecewise-linear ramp over the hue circle.
`timescale 1ns / 1ps
module rhc_lane #(
	parameter int B = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [B+2:0] x,
	input  logic [B-1:0] c1,
	input  logic [B-1:0] c2,
	output logic [B-1:0] val
);
	import rhc_pkg::*;

	localparam logic [B+2:0] TURN  = (B+3)'(1) << B;
	localparam logic [B+2:0] TURN3 = TURN + (TURN << 1);
	localparam logic [B+2:0] TURN4 = TURN << 2;

	seg_t           seg;
	logic [B:0]     frac;
	logic [B-1:0]   diff;
	logic [2*B:0]   prod_s3;
	seg_t           seg_s3;
	logic [B-1:0]   c1_s3;
	logic [B-1:0]   c2_s3;
	logic [2*B:0]   rnd;

	assign diff = c2 - c1;

	always_comb begin
		frac = '0;
		if (x < TURN) begin
			seg  = SEG_RISE;
			frac = x[B:0];
		end else if (x < TURN3) begin
			seg = SEG_HIGH;
		end else if (x < TURN4) begin
			seg  = SEG_FALL;
			frac = (B+1)'(TURN4 - x);
		end else begin
			seg = SEG_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= {1'b0, diff} * frac;
			seg_s3  <= seg;
			c1_s3   <= c1;
			c2_s3   <= c2;
		end
	end

	assign rnd = prod_s3 + ((2*B+1)'(1) << (B - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (seg_s3)
				SEG_RISE, SEG_FALL: val <= c1_s3 + rnd[2*B-1:B];
				SEG_HIGH:           val <= c2_s3;
				SEG_LOW:            val <= c1_s3;
				default:            val <= c1_s3;
			endcase
		end
	end
endmodule

FILE: hw/rtl/rgb_hsl_convert.sv
// Top level: RGB <-> HSL pixel converter.
//
//  channel  | dir | beat payload
//  ---------+-----+------------------------------------------
//  pix_in   | in  | comp_a, comp_b, comp_c  (RGB or H,S,L)
//  pix_out  | out | out_a, out_b, out_c     (H,S,L or RGB)
//  cfg      | in  | cfg_we, cfg_wdata       (direction)
//
// One beat per clock sustained while results are taken. The bit-per-stage divider
// pipelines (two of them) are shared by both directions.
// Three channel lanes then a merge/output register finish HSL to RGB.
// Whole pipeline advances whenever the output register is empty or taken.
// Reset clears valids and direction only.
`timescale 1ns / 1ps
module rgb_hsl_convert #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	rhc_in_if.sink    pix_in,
	rhc_out_if.source pix_out
);
	import rhc_pkg::*;

	localparam int B  = CHANNEL_BITS;
	localparam int DW = B + 4;
	localparam int QW = B + 1;
	localparam int NW = DW + QW;
	localparam logic [B-1:0]   FULL  = {B{1'b1}};
	localparam logic [B+2:0]   TURN  = (B+3)'(1) << B;
	localparam logic [B+2:0]   TURN2 = TURN << 1;
	localparam logic [B+2:0]   TURN4 = TURN << 2;
	localparam logic [B+2:0]   TURN6 = TURN4 + TURN2;

	typedef struct packed {
		logic         dir;
		logic         grey;
		logic         szero;
		logic [B:0]   lsum;
		logic [B-1:0] l;
		logic [B-1:0] h;
	} side_t;

	logic dir_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_RGB2HSL;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
		end
	end

	assign en           = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = en;

	// ---- stage 1: capture beat
	logic         v_s1, dir_s1;
	logic [B-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= pix_in.comp_a;
			b_s1   <= pix_in.comp_b;
			c_s1   <= pix_in.comp_c;
			dir_s1 <= dir_q;
		end
	end

	// ---- stage 2: max/min, sector numerator, HSL product
	logic [B-1:0] mx, mn, d;
	logic [B:0]   sum, den;
	logic [B+2:0] n, d6;

	always_comb begin
		mx = a_s1;
		mn = a_s1;
		if (b_s1 > mx) mx = b_s1;
		if (c_s1 > mx) mx = c_s1;
		if (b_s1 < mn) mn = b_s1;
		if (c_s1 < mn) mn = c_s1;
		d   = mx - mn;
		d6  = {2'b0, d, 1'b0} + {1'b0, d, 2'b0};
		sum = {1'b0, mx} + {1'b0, mn};
		den = (sum < {1'b0, FULL}) ? sum : (B+1)'({FULL, 1'b0} - sum);
		// negative red-sector difference folded by a full turn (6d)
		if (a_s1 == mx)
			n = d6 + {3'b0, b_s1} - {3'b0, c_s1};
		else if (b_s1 == mx)
			n = {2'b0, d, 1'b0} + {3'b0, c_s1} - {3'b0, a_s1};
		else
			n = {1'b0, d, 2'b0} + {3'b0, a_s1} - {3'b0, b_s1};
		if (n >= d6)
			n = n - d6;
	end

	logic           v_s2, dir_s2, grey_s2;
	logic [B-1:0]   d_s2, a_s2, b_s2, c_s2;
	logic [B:0]     sum_s2, den_s2;
	logic [B+2:0]   n_s2;
	logic [2*B-1:0] ls_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s2  <= dir_s1;
			grey_s2 <= (mx == mn);
			d_s2    <= d;
			sum_s2  <= sum;
			den_s2  <= den;
			n_s2    <= n;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			ls_s2   <= c_s1 * b_s1;
		end
	end

	// ---- divider operands
	logic [NW-1:0] lf, ls, ladd, t2, t1;
	logic [NW-1:0] num_x, num_y;
	logic [DW-1:0] den_x, den_y;
	logic          grey_eff;

	always_comb begin
		lf   = (NW'(c_s2) << B) - NW'(c_s2);
		ls   = NW'(ls_s2);
		ladd = NW'(c_s2) + NW'(b_s2);
		if ({c_s2, 1'b0} < {1'b0, FULL})
			t2 = lf + ls;
		else
			t2 = (ladd << B) - ladd - ls;
		t1 = (lf << 1) - t2;
		// grey input makes d zero; keep a non-zero divisor, result unused
		grey_eff = grey_s2;
		if (dir_s2 == DIR_RGB2HSL) begin
			num_x = ((NW'(d_s2) << B) - NW'(d_s2)) * 2 + NW'(den_s2);
			den_x = grey_eff ? DW'(1) : DW'({den_s2, 1'b0});
			num_y = (NW'(n_s2) << (B + 1)) + 6 * NW'(d_s2);
			den_y = grey_eff ? DW'(1) : DW'(12 * {4'b0, d_s2});
		end else begin
			num_x = (t2 << 1) + NW'(FULL);
			den_x = DW'({FULL, 1'b0});
			num_y = (t1 << 1) + NW'(FULL);
			den_y = DW'({FULL, 1'b0});
		end
	end

	logic [QW-1:0] quo_x, quo_y;

	rhc_div #(.DW(DW), .QW(QW)) u_div_x (
		.clk (clk), .en (en), .num (num_x), .den (den_x), .quo (quo_x)
	);
	rhc_div #(.DW(DW), .QW(QW)) u_div_y (
		.clk (clk), .en (en), .num (num_y), .den (den_y), .quo (quo_y)
	);

	// sideband delay line alongside the dividers and lanes
	side_t sb_in;
	side_t sb_q [QW+2];

	assign sb_in = '{dir: dir_s2, grey: grey_s2, szero: (b_s2 == '0),
		lsum: sum_s2, l: c_s2, h: a_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			sb_q[0] <= sb_in;
			for (int k = 1; k < QW + 2; k++) sb_q[k] <= sb_q[k-1];
		end
	end

	// ---- lanes: positions in units of 1/6 turn times T
	side_t        sbd;
	logic [B+2:0] p, xr, xb;
	logic [B-1:0] c1, c2;

	assign sbd = sb_q[QW-1];
	assign c2  = quo_x[B-1:0];
	assign c1  = quo_y[B-1:0];

	always_comb begin
		p  = {2'b0, sbd.h, 1'b0} + {1'b0, sbd.h, 2'b0};
		xr = p + TURN2;
		if (xr > TURN6) xr = xr - TURN6;
		xb = (p >= TURN2) ? (p - TURN2) : (p + TURN4);
	end

	logic [B-1:0] red, green, blue;

	rhc_lane #(.B(B)) u_lane_r (.clk(clk), .en(en), .x(xr), .c1(c1), .c2(c2), .val(red));
	rhc_lane #(.B(B)) u_lane_g (.clk(clk), .en(en), .x(p),  .c1(c1), .c2(c2), .val(green));
	rhc_lane #(.B(B)) u_lane_b (.clk(clk), .en(en), .x(xb), .c1(c1), .c2(c2), .val(blue));

	// RGB to HSL results wait out the lane stages
	logic [B-1:0] hue_s3, sat_s3, hue_s4, sat_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s3 <= quo_y[B-1:0];
			sat_s3 <= quo_x[B-1:0];
			hue_s4 <= hue_s3;
			sat_s4 <= sat_s3;
		end
	end

	// ---- merge / output register
	side_t        sbo;
	logic [B:0]   lrnd;
	logic [B-1:0] oa_s5, ob_s5, oc_s5;

	assign sbo  = sb_q[QW+1];
	assign lrnd = sbo.lsum + (B+1)'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			if (sbo.dir == DIR_RGB2HSL) begin
				oa_s5 <= sbo.grey ? '0 : hue_s4;
				ob_s5 <= sbo.grey ? '0 : sat_s4;
				oc_s5 <= lrnd[B:1];
			end else if (sbo.szero) begin
				oa_s5 <= sbo.l;
				ob_s5 <= sbo.l;
				oc_s5 <= sbo.l;
			end else begin
				oa_s5 <= red;
				ob_s5 <= green;
				oc_s5 <= blue;
			end
		end
	end

	assign pix_out.out_a = oa_s5;
	assign pix_out.out_b = ob_s5;
	assign pix_out.out_c = oc_s5;

	// ---- valid line
	logic [QW+1:0] vd_q;
	logic          v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vd_q <= '0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_in.valid;
			v_s2 <= v_s1;
			vd_q <= {vd_q[QW:0], v_s2};
			v_s5 <= vd_q[QW+1];
		end
	end

	assign pix_out.valid = v_s5;
endmodule

FILE: hw/rtl/rhc_check.sv
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
module rhc_check #(
	parameter int W = 16
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] out_a,
	input logic [W-1:0] out_b,
	input logic [W-1:0] out_c
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_a) && $stable(out_b) && $stable(out_c))
		else $error("result payload changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without a stalled result");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not taken with output register empty");
endmodule

bind rgb_hsl_convert rhc_check #(.W(CHANNEL_BITS)) u_rhc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_a     (pix_out.out_a),
	.out_b     (pix_out.out_b),
	.out_c     (pix_out.out_c)
);
